// File: rtl/pwmpc_pkg.sv
// ----------------------------------------------------------------------------
// pwmpc_pkg
// Shared widths and the payload that runs down the divider chain.
// ----------------------------------------------------------------------------
package pwmpc_pkg;

    localparam int FREQ_W = 32;   // switching frequency field
    localparam int DUTY_W = 16;   // Q0.16 duty field
    localparam int DIV_W  = 32;   // quotient bits, one cell per bit

    localparam int EXP_OUT_W = 3;
    localparam int CNT_OUT_W = 16;

    // Partial division result handed from cell to cell.
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  quo;
    } t_div_data;

endpackage

// File: rtl/pwmpc_div_cell.sv
// ----------------------------------------------------------------------------
// pwmpc_div_cell
// One restoring-division step: shift in a bit of the constant dividend,
// subtract the frequency when it fits, shift the quotient bit in.
// ----------------------------------------------------------------------------
module pwmpc_div_cell #(
    parameter logic DIV_BIT = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  pwmpc_pkg::t_div_data  i_data,
    output logic                  o_valid,
    output pwmpc_pkg::t_div_data  o_data
);
    import pwmpc_pkg::*;

    logic              r_valid;
    t_div_data         r_data;
    t_div_data         n_data;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              take;

    always_comb begin
        shifted = {i_data.rem, DIV_BIT};
        diff    = shifted - {1'b0, i_data.freq};
        take    = (shifted >= {1'b0, i_data.freq});
        n_data      = i_data;
        n_data.rem  = take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        n_data.quo  = {i_data.quo[DIV_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/pwmpc_finish.sv
// ----------------------------------------------------------------------------
// pwmpc_finish
// Pick the prescale exponent, scale the period by duty, round and clamp.
// ----------------------------------------------------------------------------
module pwmpc_finish #(
    parameter int MAX_PRESCALE_EXP = 7,
    parameter int PERIOD_BITS      = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ce,
    input  logic                                i_valid,
    input  logic [pwmpc_pkg::FREQ_W-1:0]        i_freq,
    input  logic [pwmpc_pkg::DUTY_W-1:0]        i_duty,
    input  logic [pwmpc_pkg::DIV_W-1:0]         i_quo,
    output logic                                o_valid,
    output logic [pwmpc_pkg::EXP_OUT_W-1:0]     o_exp,
    output logic [pwmpc_pkg::CNT_OUT_W-1:0]     o_period,
    output logic [pwmpc_pkg::CNT_OUT_W-1:0]     o_cmp,
    output logic                                o_fallback
);
    import pwmpc_pkg::*;

    localparam int EW = (MAX_PRESCALE_EXP > 1) ? $clog2(MAX_PRESCALE_EXP + 1) : 1;
    localparam int PW = PERIOD_BITS + DUTY_W;
    localparam logic [DIV_W:0] PMAX = ({{DIV_W{1'b0}}, 1'b1} << PERIOD_BITS) - 1'b1;
    localparam logic [DIV_W:0] PMIN = (DIV_W+1)'(3);
    localparam logic [PW:0]    HALF = (PW+1)'(1) << (DUTY_W - 1);

    // Select stage
    logic [EW-1:0]          sel_exp;
    logic [PERIOD_BITS-1:0] sel_period;
    logic                   sel_found;
    logic [DIV_W:0]         shq;

    always_comb begin
        sel_exp    = EW'(MAX_PRESCALE_EXP);
        sel_period = PMAX[PERIOD_BITS-1:0];
        sel_found  = 1'b0;
        // Walk down so the smallest fitting exponent wins.
        for (int e = MAX_PRESCALE_EXP; e >= 0; e--) begin
            shq = {1'b0, i_quo} >> e;
            if (i_freq != '0 && shq >= PMIN && shq <= PMAX) begin
                sel_exp    = EW'(e);
                sel_period = shq[PERIOD_BITS-1:0];
                sel_found  = 1'b1;
            end
        end
    end

    logic                   r_s_valid;
    logic [EW-1:0]          r_s_exp;
    logic [PERIOD_BITS-1:0] r_s_period;
    logic                   r_s_found;
    logic [DUTY_W-1:0]      r_s_duty;

    // Multiply stage
    logic                   r_m_valid;
    logic [EW-1:0]          r_m_exp;
    logic [PERIOD_BITS-1:0] r_m_period;
    logic                   r_m_found;
    logic [PW-1:0]          r_m_prod;

    // Round and clamp into the output register
    logic [PW:0]            rsum;
    logic [PERIOD_BITS:0]   rcmp;
    logic [PERIOD_BITS:0]   n_cmp;

    always_comb begin
        rsum = {1'b0, r_m_prod} + HALF;
        rcmp = rsum[PW:DUTY_W];
        if (rcmp >= {1'b0, r_m_period}) begin
            n_cmp = {1'b0, r_m_period} - 1'b1;
        end else if (rcmp == '0) begin
            n_cmp = (PERIOD_BITS+1)'(1);
        end else begin
            n_cmp = rcmp;
        end
    end

    logic                   r_o_valid;
    logic [EW-1:0]          r_o_exp;
    logic [PERIOD_BITS-1:0] r_o_period;
    logic [PERIOD_BITS:0]   r_o_cmp;
    logic                   r_o_fallback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_ce) begin
            r_s_valid <= i_valid;
            r_m_valid <= r_s_valid;
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s_exp      <= sel_exp;
            r_s_period   <= sel_period;
            r_s_found    <= sel_found;
            r_s_duty     <= i_duty;
            r_m_exp      <= r_s_exp;
            r_m_period   <= r_s_period;
            r_m_found    <= r_s_found;
            r_m_prod     <= PW'(r_s_period) * PW'(r_s_duty);
            r_o_exp      <= r_m_exp;
            r_o_period   <= r_m_period;
            r_o_cmp      <= n_cmp;
            r_o_fallback <= !r_m_found;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_exp      = EXP_OUT_W'(r_o_exp);
    assign o_period   = CNT_OUT_W'(r_o_period);
    assign o_cmp      = CNT_OUT_W'(r_o_cmp);
    assign o_fallback = r_o_fallback;

endmodule

// File: rtl/pwm_prescaler_period_calc_top.sv
// ----------------------------------------------------------------------------
// pwm_prescaler_period_calc_top
// Timer prescaler, period and compare calculation from frequency and duty.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata: freq_hz, duty_fraction
//  m_axis    out  tvalid/tready        tdata: exp, period, compare; tuser: fallback
//
//  One request per cycle, sustained while the output is not stalled. The chain is 32 division cells
//  (one quotient bit each), then exponent select, multiply, round/clamp.
//  The whole chain advances together whenever the output register is empty
//  or being taken; a stalled output holds every stage in place.
//  Reset clears all stage valid flags.
// ----------------------------------------------------------------------------
module pwm_prescaler_period_calc_top #(
    parameter logic [31:0] TIMER_CLOCK_HZ   = 32'd4000000000,
    parameter int          MAX_PRESCALE_EXP = 7,
    parameter int          PERIOD_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] freq_hz, [47:32] duty_fraction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] prescale_exp, [18:3] period_count,
                                        // [34:19] compare_count, [39:35] zero
    output logic [0:0]  m_axis_tuser    // [0] range_fallback
);
    import pwmpc_pkg::*;

    localparam int NCELL = DIV_W;

    logic      ce;
    logic      stg_valid [0:NCELL];
    t_div_data stg_data  [0:NCELL];

    logic                  fin_valid;
    logic [EXP_OUT_W-1:0]  fin_exp;
    logic [CNT_OUT_W-1:0]  fin_period;
    logic [CNT_OUT_W-1:0]  fin_cmp;
    logic                  fin_fallback;

    // Advance the whole chain when the output slot is free or drains now.
    assign ce            = !fin_valid || m_axis_tready;
    assign s_axis_tready = ce;

    // Head of the chain: empty remainder and quotient.
    always_comb begin
        stg_valid[0]     = s_axis_tvalid;
        stg_data[0].freq = s_axis_tdata[FREQ_W-1:0];
        stg_data[0].duty = s_axis_tdata[FREQ_W+DUTY_W-1:FREQ_W];
        stg_data[0].rem  = '0;
        stg_data[0].quo  = '0;
    end

    // Dividend bits enter MSB first, one per cell.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        pwmpc_div_cell #(
            .DIV_BIT (TIMER_CLOCK_HZ[NCELL-1-k])
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (stg_valid[k]),
            .i_data  (stg_data[k]),
            .o_valid (stg_valid[k+1]),
            .o_data  (stg_data[k+1])
        );
    end

    pwmpc_finish #(
        .MAX_PRESCALE_EXP (MAX_PRESCALE_EXP),
        .PERIOD_BITS      (PERIOD_BITS)
    ) u_finish (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (ce),
        .i_valid    (stg_valid[NCELL]),
        .i_freq     (stg_data[NCELL].freq),
        .i_duty     (stg_data[NCELL].duty),
        .i_quo      (stg_data[NCELL].quo),
        .o_valid    (fin_valid),
        .o_exp      (fin_exp),
        .o_period   (fin_period),
        .o_cmp      (fin_cmp),
        .o_fallback (fin_fallback)
    );

    assign m_axis_tvalid   = fin_valid;
    assign m_axis_tdata    = {5'b0, fin_cmp, fin_period, fin_exp};
    assign m_axis_tuser[0] = fin_fallback;

endmodule
